// ===== rtl/core/grid_astar_search_unit_macros.svh =====
// Assertion macros for the grid A* search unit.
// Included by the RTL files that carry concurrent checks; needs a clk and rst in scope.
`ifndef GRID_ASTAR_SEARCH_UNIT_MACROS_SVH
`define GRID_ASTAR_SEARCH_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define GAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define GAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GAS_ASSERT_NOW(lbl, ante, cons, msg)
`define GAS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gas_pkg.sv =====
// Shared types, codes and helpers for the grid A* search unit.
// No dependencies; used by gas_regs, gas_engine and the top level.
package gas_pkg;

  localparam int GRID_COLS_DEF = 32;
  localparam int GRID_ROWS_DEF = 32;
  localparam int G_W = 18;
  localparam logic [G_W-1:0] G_MAX = 18'h3FFFF;
  localparam int DIM_W = 9;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_EXPAND  = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACK         = 3'd0,
    ST_EXPANDED    = 3'd1,
    ST_GOAL        = 3'd2,
    ST_NO_PATH     = 3'd3,
    ST_FINISHED    = 3'd4,
    ST_OUT_OF_PATH = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_FOUND  = 2'd2,
    PH_NOPATH = 2'd3
  } phase_t;

  // neighbour order: (-1,0) (0,+1) (+1,0) (0,-1) in (col,row)
  typedef enum logic [1:0] {
    DIR_W = 2'd0,
    DIR_S = 2'd1,
    DIR_E = 2'd2,
    DIR_N = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_START_X     = 3'd2,
    REG_START_Y     = 3'd3,
    REG_GOAL_X      = 3'd4,
    REG_GOAL_Y      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [5:0] grid_width;
    logic [5:0] grid_height;
    logic [4:0] start_x;
    logic [4:0] start_y;
    logic [4:0] goal_x;
    logic [4:0] goal_y;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] col;
    logic [4:0] row;
    logic [G_W-1:0] cost_g;
    logic [10:0] path_length;
  } res_t;

  // clamp a size register to 1..lim
  function automatic logic [DIM_W-1:0] clamp_dim(logic [5:0] v, int unsigned lim);
    logic [DIM_W-1:0] r;
    r = DIM_W'(v);
    if (v == 6'd0) r = DIM_W'(1);
    else if (32'(v) > lim) r = DIM_W'(lim);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] absdiff(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/core/grid_astar_search_unit.sv =====
// Top level of the grid A* search unit: config registers, search engine, output register.
// Depends on gas_pkg, gas_regs, gas_engine (and through it gas_ram).
//
// Usage:
//  - APB port sets grid size, start and goal; write only while the block is idle.
//  - Input channel (in_valid / in_stall) carries one command beat: op plus its operands.
//    op 0 loads a cell cost, op 1 restarts the search, op 2 runs one expansion,
//    op 3 reads one path entry. Every command returns exactly one result beat.
//  - Output channel (out_valid / out_stall) carries status, cell, G and path length.
//  - One command at a time. Steps from accept to result ready:
//      load and out-of-path read go straight to the result, path read reads the path then G,
//      restart clears the mark store (one mark entry cleared per cycle), then opens the start,
//      expand scans every cell (one cell per cycle through the
//      mark/G read ports), then steps once per direction and once per in-bounds neighbour;
//      goal expansion adds a parent walk with a check and a step state per path cell.
//  - The output register lets the next command be accepted while a result waits;
//    the engine then holds its own result until the output register frees up.
//  - Reset restores the register defaults, empties the output and puts the search
//    in idle; cost and G stores are not cleared, so load costs before searching.
module grid_astar_search_unit #(
  parameter int GRID_COLS = gas_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gas_pkg::GRID_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // command channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [4:0]        cell_col,
  input  logic [4:0]        cell_row,
  input  logic signed [8:0] cell_cost,
  input  logic [9:0]        path_index,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [4:0]        out_col,
  output logic [4:0]        out_row,
  output logic [17:0]       out_cost_g,
  output logic [10:0]       path_length
);

  gas_pkg::cfg_t cfg;
  gas_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  gas_regs u_regs (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cfg(cfg)
  );

  gas_engine #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .cell_col(cell_col), .cell_row(cell_row),
    .cell_cost(cell_cost), .path_index(path_index),
    .res_valid(res_valid), .res(res), .res_ready(res_ready)
  );

  // output register: free when empty or when its beat is taken this cycle
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      out_col     <= res.col;
      out_row     <= res.row;
      out_cost_g  <= res.cost_g;
      path_length <= res.path_length;
    end
  end

endmodule

// ===== rtl/core/gas_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gas_regs.sv =====
// APB configuration registers of the grid A* search unit.
// Depends on gas_pkg (cfg_t, register indexes).
module gas_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output gas_pkg::cfg_t cfg
);

  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width  <= 6'd32;
      cfg.grid_height <= 6'd32;
      cfg.start_x     <= 5'd0;
      cfg.start_y     <= 5'd0;
      cfg.goal_x      <= 5'd0;
      cfg.goal_y      <= 5'd0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        gas_pkg::REG_GRID_WIDTH:  cfg.grid_width  <= pwdata[5:0];
        gas_pkg::REG_GRID_HEIGHT: cfg.grid_height <= pwdata[5:0];
        gas_pkg::REG_START_X:     cfg.start_x     <= pwdata[4:0];
        gas_pkg::REG_START_Y:     cfg.start_y     <= pwdata[4:0];
        gas_pkg::REG_GOAL_X:      cfg.goal_x      <= pwdata[4:0];
        gas_pkg::REG_GOAL_Y:      cfg.goal_y      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gas_pkg::REG_GRID_WIDTH:  prdata = 32'(cfg.grid_width);
      gas_pkg::REG_GRID_HEIGHT: prdata = 32'(cfg.grid_height);
      gas_pkg::REG_START_X:     prdata = 32'(cfg.start_x);
      gas_pkg::REG_START_Y:     prdata = 32'(cfg.start_y);
      gas_pkg::REG_GOAL_X:      prdata = 32'(cfg.goal_x);
      gas_pkg::REG_GOAL_Y:      prdata = 32'(cfg.goal_y);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/gas_engine.sv =====
// Search engine: sequencer plus the cell memories (cost, mark, G, parent, path).
// Depends on gas_pkg, gas_ram and grid_astar_search_unit_macros.svh.
`include "grid_astar_search_unit_macros.svh"
module gas_engine #(
  parameter int GRID_COLS = gas_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gas_pkg::GRID_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gas_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [4:0]        cell_col,
  input  logic [4:0]        cell_row,
  input  logic signed [8:0] cell_cost,
  input  logic [9:0]        path_index,
  output logic              res_valid,
  output gas_pkg::res_t     res,
  input  logic              res_ready
);

  localparam int NC  = GRID_COLS * GRID_ROWS;
  localparam int XW  = $clog2(GRID_COLS);
  localparam int YW  = $clog2(GRID_ROWS);
  localparam int CW  = $clog2(NC);
  localparam int PCW = $clog2(NC + 1);
  localparam int GW  = gas_pkg::G_W;
  localparam int FW  = GW + 1;
  localparam int PW  = XW + YW;
  localparam int DW  = gas_pkg::DIM_W;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLEAR = 14'b00000000000010,
    S_ROPEN = 14'b00000000000100,
    S_SCAN  = 14'b00000000001000,
    S_TAIL  = 14'b00000000010000,
    S_PICK  = 14'b00000000100000,
    S_NBI   = 14'b00000001000000,
    S_NBU   = 14'b00000010000000,
    S_PBC   = 14'b00000100000000,
    S_PBS   = 14'b00001000000000,
    S_PRA   = 14'b00010000000000,
    S_PRB   = 14'b00100000000000,
    S_PRC   = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t            state;
  gas_pkg::phase_t   phase;
  logic [PCW-1:0]    path_count;
  gas_pkg::res_t     res_r;

  logic [XW-1:0]     sx, px, bx, cx;
  logic [YW-1:0]     sy, py, by, cy;
  logic [CW-1:0]     sidx, pidx, bidx, nidx, pr_addr;
  logic              pv, found;
  logic [GW-1:0]     bg;
  logic [FW-1:0]     bestf;
  gas_pkg::dir_t     dir;

  // memory ports
  logic           cost_we, mark_we, g_we, par_we, path_we;
  logic [CW-1:0]  cost_waddr, mark_waddr, g_waddr, par_waddr, path_waddr;
  logic [CW-1:0]  cost_raddr, mark_raddr, g_raddr, par_raddr, path_raddr;
  logic [8:0]     cost_wdata, cost_rdata;
  logic [1:0]     mark_wdata, mark_rdata;   // bit0 open, bit1 closed
  logic [GW-1:0]  g_wdata, g_rdata;
  logic [1:0]     par_wdata, par_rdata;
  logic [PW-1:0]  path_wdata, path_rdata;

  logic           accept, load_ok, start_ok, at_goal, at_start;
  logic [DW-1:0]  used_w, used_h;
  logic [CW-1:0]  st_idx, nb_idx;
  logic [XW:0]    nbx, pwx;
  logic [YW:0]    nby, pwy;
  logic           nb_ok, pw_ok, take, upd;
  logic [FW-1:0]  f, ng_sum;
  logic [GW-1:0]  ng;
  logic [XW-1:0]  rx;
  logic [YW-1:0]  ry;

  function automatic logic [CW-1:0] cell_idx(logic [XW-1:0] x, logic [YW-1:0] y);
    return CW'(32'(y) * GRID_COLS + 32'(x));
  endfunction

  function automatic gas_pkg::res_t make_res(gas_pkg::status_t st, logic [XW-1:0] x,
                                             logic [YW-1:0] y, logic [GW-1:0] g,
                                             logic [PCW-1:0] plen);
    gas_pkg::res_t r;
    r.status      = st;
    r.col         = 5'(x);
    r.row         = 5'(y);
    r.cost_g      = g;
    r.path_length = 11'(plen);
    return r;
  endfunction

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign res       = res_r;

  assign used_w   = gas_pkg::clamp_dim(cfg.grid_width, GRID_COLS);
  assign used_h   = gas_pkg::clamp_dim(cfg.grid_height, GRID_ROWS);
  assign load_ok  = (32'(cell_col) < GRID_COLS) && (32'(cell_row) < GRID_ROWS);
  assign start_ok = (DW'(cfg.start_x) < used_w) && (DW'(cfg.start_y) < used_h);
  assign st_idx   = cell_idx(XW'(cfg.start_x), YW'(cfg.start_y));
  assign at_goal  = (32'(bx) == 32'(cfg.goal_x)) && (32'(by) == 32'(cfg.goal_y));
  assign at_start = (32'(cx) == 32'(cfg.start_x)) && (32'(cy) == 32'(cfg.start_y));

  // scan datapath: F = G + Manhattan distance, least F wins, ties keep the earlier cell
  assign f = FW'(g_rdata)
           + FW'(gas_pkg::absdiff(DW'(px), DW'(cfg.goal_x)))
           + FW'(gas_pkg::absdiff(DW'(py), DW'(cfg.goal_y)));
  assign take = pv && mark_rdata[0] && (!found || (f < bestf));

  // neighbour of the expanded cell in direction dir
  always_comb begin
    nbx   = {1'b0, bx};
    nby   = {1'b0, by};
    nb_ok = 1'b1;
    case (dir)
      gas_pkg::DIR_W: begin
        nb_ok = (bx != '0);
        nbx   = {1'b0, bx} - (XW+1)'(1);
      end
      gas_pkg::DIR_S: nby = {1'b0, by} + (YW+1)'(1);
      gas_pkg::DIR_E: nbx = {1'b0, bx} + (XW+1)'(1);
      gas_pkg::DIR_N: begin
        nb_ok = (by != '0);
        nby   = {1'b0, by} - (YW+1)'(1);
      end
      default: nb_ok = 1'b0;
    endcase
    nb_ok = nb_ok && (DW'(nbx) < used_w) && (DW'(nby) < used_h);
  end
  assign nb_idx = cell_idx(nbx[XW-1:0], nby[YW-1:0]);

  // relaxation
  assign ng_sum = {1'b0, bg} + FW'(cost_rdata[7:0]);
  assign ng     = ng_sum[FW-1] ? gas_pkg::G_MAX : ng_sum[GW-1:0];
  assign upd    = !cost_rdata[8] && !mark_rdata[1] && (!mark_rdata[0] || (ng < g_rdata));

  // parent of the walk cell: step back against the stored direction
  always_comb begin
    pwx   = {1'b0, cx};
    pwy   = {1'b0, cy};
    pw_ok = 1'b1;
    case (gas_pkg::dir_t'(par_rdata))
      gas_pkg::DIR_W: pwx = {1'b0, cx} + (XW+1)'(1);
      gas_pkg::DIR_S: begin
        pw_ok = (cy != '0);
        pwy   = {1'b0, cy} - (YW+1)'(1);
      end
      gas_pkg::DIR_E: begin
        pw_ok = (cx != '0);
        pwx   = {1'b0, cx} - (XW+1)'(1);
      end
      gas_pkg::DIR_N: pwy = {1'b0, cy} + (YW+1)'(1);
      default: pw_ok = 1'b0;
    endcase
    pw_ok = pw_ok && (32'(pwx) < GRID_COLS) && (32'(pwy) < GRID_ROWS);
  end

  assign rx = path_rdata[XW-1:0];
  assign ry = path_rdata[PW-1:XW];

  // memory port steering
  always_comb begin
    cost_we    = accept && (op == gas_pkg::OP_LOAD) && load_ok;
    cost_waddr = cell_idx(XW'(cell_col), YW'(cell_row));
    cost_wdata = cell_cost;
    cost_raddr = nb_idx;

    mark_we    = 1'b0;
    mark_waddr = sidx;
    mark_wdata = 2'b00;
    g_we       = 1'b0;
    g_waddr    = nidx;
    g_wdata    = ng;
    par_we     = 1'b0;
    par_waddr  = nidx;
    par_wdata  = dir;
    path_we    = 1'b0;
    path_waddr = CW'(path_count);
    path_wdata = {pwy[YW-1:0], pwx[XW-1:0]};
    par_raddr  = cell_idx(cx, cy);
    path_raddr = pr_addr;
    mark_raddr = sidx;
    g_raddr    = sidx;

    case (state)
      S_CLEAR: mark_we = 1'b1;
      S_ROPEN: begin
        mark_we    = start_ok;
        mark_waddr = st_idx;
        mark_wdata = 2'b01;
        g_we       = start_ok;
        g_waddr    = st_idx;
        g_wdata    = '0;
      end
      S_PICK: begin
        mark_we    = found;
        mark_waddr = bidx;
        mark_wdata = 2'b10;
        path_we    = found && at_goal;
        path_waddr = '0;
        path_wdata = {by, bx};
      end
      S_NBI: begin
        mark_raddr = nb_idx;
        g_raddr    = nb_idx;
      end
      S_NBU: begin
        mark_we    = upd;
        mark_waddr = nidx;
        mark_wdata = 2'b01;
        g_we       = upd;
        par_we     = upd;
      end
      S_PBS: path_we = pw_ok;
      S_PRB: g_raddr = cell_idx(rx, ry);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= gas_pkg::PH_IDLE;
      path_count <= '0;
      pv         <= 1'b0;
      found      <= 1'b0;
    end else begin
      // read data of a scanned cell lands in the cycle after its address
      pv <= (state == S_SCAN);
      if (take) begin
        found <= 1'b1;
        bestf <= f;
        bx    <= px;
        by    <= py;
        bidx  <= pidx;
        bg    <= g_rdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (gas_pkg::op_t'(op))
              gas_pkg::OP_LOAD: begin
                res_r <= make_res(gas_pkg::ST_ACK, '0, '0, '0, path_count);
                state <= S_EMIT;
              end
              gas_pkg::OP_RESTART: begin
                path_count <= '0;
                phase      <= gas_pkg::PH_SEARCH;
                sidx       <= '0;
                state      <= S_CLEAR;
              end
              gas_pkg::OP_EXPAND: begin
                if (phase == gas_pkg::PH_FOUND || phase == gas_pkg::PH_NOPATH) begin
                  res_r <= make_res(gas_pkg::ST_FINISHED, '0, '0, '0, path_count);
                  state <= S_EMIT;
                end else if (phase == gas_pkg::PH_IDLE) begin
                  // nothing was ever opened
                  phase <= gas_pkg::PH_NOPATH;
                  res_r <= make_res(gas_pkg::ST_NO_PATH, '0, '0, '0, path_count);
                  state <= S_EMIT;
                end else begin
                  sidx  <= '0;
                  sx    <= '0;
                  sy    <= '0;
                  found <= 1'b0;
                  state <= S_SCAN;
                end
              end
              gas_pkg::OP_READ: begin
                if (32'(path_index) < 32'(path_count)) begin
                  // path is stored goal first
                  pr_addr <= CW'(32'(path_count) - 32'(path_index) - 32'd1);
                  state   <= S_PRA;
                end else begin
                  res_r <= make_res(gas_pkg::ST_OUT_OF_PATH, '0, '0, '0, path_count);
                  state <= S_EMIT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLEAR: begin
          sidx <= sidx + CW'(1);
          if (sidx == CW'(NC - 1)) state <= S_ROPEN;
        end
        S_ROPEN: begin
          res_r <= make_res(gas_pkg::ST_ACK, '0, '0, '0, path_count);
          state <= S_EMIT;
        end
        S_SCAN: begin
          px   <= sx;
          py   <= sy;
          pidx <= sidx;
          sidx <= sidx + CW'(1);
          if (sx == XW'(GRID_COLS - 1)) begin
            sx <= '0;
            sy <= sy + YW'(1);
          end else begin
            sx <= sx + XW'(1);
          end
          if (sidx == CW'(NC - 1)) state <= S_TAIL;
        end
        S_TAIL: state <= S_PICK;
        S_PICK: begin
          if (!found) begin
            phase <= gas_pkg::PH_NOPATH;
            res_r <= make_res(gas_pkg::ST_NO_PATH, '0, '0, '0, path_count);
            state <= S_EMIT;
          end else if (at_goal) begin
            path_count <= PCW'(1);
            cx         <= bx;
            cy         <= by;
            state      <= S_PBC;
          end else begin
            dir   <= gas_pkg::DIR_W;
            state <= S_NBI;
          end
        end
        S_NBI: begin
          if (nb_ok) begin
            nidx  <= nb_idx;
            state <= S_NBU;
          end else if (dir == gas_pkg::DIR_N) begin
            res_r <= make_res(gas_pkg::ST_EXPANDED, bx, by, bg, path_count);
            state <= S_EMIT;
          end else begin
            dir <= gas_pkg::dir_t'(dir + 2'd1);
          end
        end
        S_NBU: begin
          if (dir == gas_pkg::DIR_N) begin
            res_r <= make_res(gas_pkg::ST_EXPANDED, bx, by, bg, path_count);
            state <= S_EMIT;
          end else begin
            dir   <= gas_pkg::dir_t'(dir + 2'd1);
            state <= S_NBI;
          end
        end
        S_PBC: begin
          if (at_start || (32'(path_count) >= NC)) begin
            phase <= gas_pkg::PH_FOUND;
            res_r <= make_res(gas_pkg::ST_GOAL, bx, by, bg, path_count);
            state <= S_EMIT;
          end else begin
            state <= S_PBS;
          end
        end
        S_PBS: begin
          if (pw_ok) begin
            path_count <= path_count + PCW'(1);
            cx         <= pwx[XW-1:0];
            cy         <= pwy[YW-1:0];
            state      <= S_PBC;
          end else begin
            phase <= gas_pkg::PH_FOUND;
            res_r <= make_res(gas_pkg::ST_GOAL, bx, by, bg, path_count);
            state <= S_EMIT;
          end
        end
        S_PRA: state <= S_PRB;
        S_PRB: begin
          cx    <= rx;
          cy    <= ry;
          state <= S_PRC;
        end
        S_PRC: begin
          res_r <= make_res(gas_pkg::ST_ACK, cx, cy, g_rdata, path_count);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gas_ram #(.WIDTH(9), .DEPTH(NC)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr(cost_raddr), .rdata(cost_rdata)
  );
  gas_ram #(.WIDTH(2), .DEPTH(NC)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );
  gas_ram #(.WIDTH(GW), .DEPTH(NC)) u_g (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );
  gas_ram #(.WIDTH(2), .DEPTH(NC)) u_par (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );
  gas_ram #(.WIDTH(PW), .DEPTH(NC)) u_path (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(path_raddr), .rdata(path_rdata)
  );

  `GAS_ASSERT_NOW(a_nb_not_best, state == S_NBU, nidx != bidx, "neighbour update hits the expanded cell")
  `GAS_ASSERT_NEXT(a_emit_to_idle, state == S_EMIT && res_ready, state == S_IDLE, "result handed over but engine not idle")
  `GAS_ASSERT_NOW(a_pick_in_range, state == S_PICK && found, 32'(bidx) < NC, "selected cell outside the grid")
  `GAS_ASSERT_NOW(a_walk_count, state == S_PBC, path_count != '0 && 32'(path_count) <= NC, "path walk count out of range")

endmodule

// ===== dv/tb_grid_astar_search_unit.sv =====
// Self-checking testbench for grid_astar_search_unit: APB setup, command beats, result checks.
// Depends on gas_pkg and the RTL of the unit; holds its own A* predictor and scoreboard class.
`timescale 1ns / 100ps
module tb_grid_astar_search_unit;
  import gas_pkg::*;

  localparam int COLS  = 32;
  localparam int ROWS  = 32;
  localparam int CELLS = COLS * ROWS;

  typedef struct {
    status_t     st;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [17:0] g;
    logic [10:0] plen;
  } result_beat_t;

  // A* predictor plus the queue of result beats it owes the monitor
  class astar_scoreboard;
    int unsigned  width_reg, height_reg, sx, sy, gx, gy;
    int           cost_mem[CELLS];
    bit           open_m[CELLS];
    bit           closed_m[CELLS];
    int unsigned  g_mem[CELLS];
    int unsigned  par_mem[CELLS];
    int unsigned  path_mem[CELLS];
    int unsigned  plen;
    phase_t       phase;
    result_beat_t owed[$];
    int unsigned  errors, checked, expands, goals, dead_ends;
    int           dxs[4];
    int           dys[4];

    function new();
      // neighbor order W S E N, as (col,row) steps
      dxs = '{-1, 0, 1, 0};
      dys = '{0, 1, 0, -1};
      width_reg = 32; height_reg = 32;
      sx = 0; sy = 0; gx = 0; gy = 0;
      plen = 0;
      phase = PH_IDLE;
      foreach (open_m[i]) begin
        open_m[i] = 0;
        closed_m[i] = 0;
      end
    endfunction

    function void set_reg(reg_idx_t r, int unsigned v);
      case (r)
        REG_GRID_WIDTH:  width_reg  = v & 63;
        REG_GRID_HEIGHT: height_reg = v & 63;
        REG_START_X:     sx = v & 31;
        REG_START_Y:     sy = v & 31;
        REG_GOAL_X:      gx = v & 31;
        REG_GOAL_Y:      gy = v & 31;
        default: ;
      endcase
    endfunction

    function int unsigned used_w();
      return (width_reg == 0) ? 1 : (width_reg > COLS) ? COLS : width_reg;
    endfunction

    function int unsigned used_h();
      return (height_reg == 0) ? 1 : (height_reg > ROWS) ? ROWS : height_reg;
    endfunction

    function int unsigned span(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void owe(status_t st, int unsigned c, int unsigned r, int unsigned g);
      result_beat_t b;
      b.st = st; b.col = c[4:0]; b.row = r[4:0]; b.g = g[17:0]; b.plen = plen[10:0];
      owed = {owed, b};
    endfunction

    // walk parents back from the goal, then store start..goal
    function void trace_path(int unsigned goal_idx);
      int unsigned sidx, n, idx, k, d;
      int x, y;
      sidx = sy * COLS + sx;
      n = 1;
      idx = goal_idx;
      while (idx != sidx && n < CELLS) begin
        d = par_mem[idx];
        x = int'(idx % COLS) - dxs[d];
        y = int'(idx / COLS) - dys[d];
        if (x < 0 || y < 0 || x >= COLS || y >= ROWS) break;
        idx = y * COLS + x;
        n++;
      end
      plen = n;
      idx = goal_idx;
      for (k = n; k > 0; k--) begin
        d = par_mem[idx];
        path_mem[k-1] = idx;
        if (k == 1) break;
        x = int'(idx % COLS) - dxs[d];
        y = int'(idx / COLS) - dys[d];
        if (x < 0 || y < 0 || x >= COLS || y >= ROWS) break;
        idx = y * COLS + x;
      end
    endfunction

    function void expand_one();
      int unsigned best, bestf, f, cg, ni, ng;
      bit found;
      int cx, cy, nx, ny;
      best = 0; bestf = 0; found = 0;
      expands++;
      // strict less-than over ascending index: lowest index wins ties
      for (int unsigned i = 0; i < CELLS; i++) begin
        if (open_m[i]) begin
          f = g_mem[i] + span(i % COLS, gx) + span(i / COLS, gy);
          if (!found || f < bestf) begin
            found = 1; bestf = f; best = i;
          end
        end
      end
      if (!found) begin
        phase = PH_NOPATH;
        dead_ends++;
        owe(ST_NO_PATH, 0, 0, 0);
        return;
      end
      open_m[best] = 0;
      closed_m[best] = 1;
      cx = best % COLS;
      cy = best / COLS;
      cg = g_mem[best];
      if (cx == gx && cy == gy) begin
        trace_path(best);
        phase = PH_FOUND;
        goals++;
        owe(ST_GOAL, cx, cy, cg);
        return;
      end
      for (int d = 0; d < 4; d++) begin
        nx = cx + dxs[d];
        ny = cy + dys[d];
        if (nx < 0 || ny < 0 || nx >= used_w() || ny >= used_h()) continue;
        ni = ny * COLS + nx;
        if (cost_mem[ni] < 0 || closed_m[ni]) continue;
        ng = cg + cost_mem[ni];
        if (ng > G_MAX) ng = G_MAX;
        if (!open_m[ni] || ng < g_mem[ni]) begin
          open_m[ni] = 1;
          g_mem[ni] = ng;
          par_mem[ni] = d;
        end
      end
      owe(ST_EXPANDED, cx, cy, cg);
    endfunction

    function void note_beat(op_t o, int unsigned c, int unsigned r,
                            logic signed [8:0] cost, int unsigned idx);
      int unsigned s, e;
      case (o)
        OP_LOAD: begin
          cost_mem[r * COLS + c] = int'(cost);
          owe(ST_ACK, 0, 0, 0);
        end
        OP_RESTART: begin
          foreach (open_m[i]) begin
            open_m[i] = 0;
            closed_m[i] = 0;
          end
          plen = 0;
          phase = PH_SEARCH;
          if (sx < used_w() && sy < used_h()) begin
            s = sy * COLS + sx;
            open_m[s] = 1;
            g_mem[s] = 0;
          end
          owe(ST_ACK, 0, 0, 0);
        end
        OP_EXPAND: begin
          if (phase == PH_FOUND || phase == PH_NOPATH) owe(ST_FINISHED, 0, 0, 0);
          else expand_one();
        end
        default: begin
          if (idx < plen) begin
            e = path_mem[idx] % CELLS;
            owe(ST_ACK, e % COLS, e / COLS, g_mem[e]);
          end else begin
            owe(ST_OUT_OF_PATH, 0, 0, 0);
          end
        end
      endcase
    endfunction

    function void check_beat(status_t st, logic [4:0] c, logic [4:0] r,
                             logic [17:0] g, logic [10:0] pl);
      result_beat_t e;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result beat status=%0d", st);
        return;
      end
      e = owed.pop_front();
      if (st !== e.st || c !== e.col || r !== e.row || g !== e.g || pl !== e.plen) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR beat %0d: exp st=%0d col=%0d row=%0d g=%0d len=%0d, ",
                    "got st=%0d col=%0d row=%0d g=%0d len=%0d"},
                   checked, e.st, e.col, e.row, e.g, e.plen, st, c, r, g, pl);
      end
    endfunction
  endclass

  logic              clk, rst;
  logic              psel, penable, pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;
  logic              in_valid, in_stall;
  logic [1:0]        op;
  logic [4:0]        cell_col, cell_row;
  logic signed [8:0] cell_cost;
  logic [9:0]        path_index;
  logic              out_valid, out_stall;
  logic [2:0]        status;
  logic [4:0]        out_col, out_row;
  logic [17:0]       out_cost_g;
  logic [10:0]       path_length;

  grid_astar_search_unit dut (.*);

  astar_scoreboard sb = new();

  bit          loaded[CELLS];   // cost store entries that were written
  int unsigned beats_sent;
  int unsigned burst_left;
  int unsigned phases_run;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result monitor: sample on the rising edge where the beat moves
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_beat(status_t'(status), out_col, out_row, out_cost_g, path_length);
  end

  // receiver stall pattern: modes from free-running to heavy backpressure
  int unsigned stall_mode, stall_cnt, stall_phase;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
      stall_phase = 0;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cnt  = $urandom_range(64, 512);
      end
      stall_cnt--;
      stall_phase++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_phase % 5) < 2;
      endcase
    end
  end

  // one command beat; bursts of back-to-back beats separated by random gaps
  task automatic send_beat(op_t o, int unsigned c, int unsigned r,
                           logic signed [8:0] cost, int unsigned idx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    op = o;
    cell_col = c[4:0];
    cell_row = r[4:0];
    cell_cost = cost;
    path_index = idx[9:0];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_beat(o, c, r, cost, idx);
    beats_sent++;
    @(negedge clk);
  endtask

  // drain everything so register writes land while the unit is idle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, int unsigned v);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 5'(int'(r) * 4);
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_reg(r, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic signed [8:0] pick_cost(int unsigned blk_pct);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < blk_pct) return -9'sd1;
    if (p < blk_pct + 5) return 9'sd255;
    if (p < blk_pct + 10) return 9'sd0;
    return 9'($urandom_range(1, 9));
  endfunction

  task automatic load_cell(int unsigned c, int unsigned r, logic signed [8:0] cost);
    send_beat(OP_LOAD, c, r, cost, $urandom_range(0, 1023));
    loaded[r * COLS + c] = 1;
  endtask

  // one search: configure, fill unknown costs, restart, expand, read back the path
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned stx, int unsigned sty,
                           int unsigned glx, int unsigned gly, int unsigned max_exp,
                           int unsigned blk_pct);
    int unsigned uw, uh, n, p, k;
    wait_idle();
    phases_run++;
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_GRID_HEIGHT, h);
    cfg_write(REG_START_X, stx);
    cfg_write(REG_START_Y, sty);
    cfg_write(REG_GOAL_X, glx);
    cfg_write(REG_GOAL_Y, gly);
    uw = sb.used_w();
    uh = sb.used_h();
    // every cell a neighbor scan can touch must hold a known cost
    for (int unsigned r = 0; r < uh; r++)
      for (int unsigned c = 0; c < uw; c++)
        if (!loaded[r * COLS + c]) load_cell(c, r, pick_cost(blk_pct));
    repeat ($urandom_range(0, 3))
      load_cell($urandom_range(0, 31), $urandom_range(0, 31), pick_cost(blk_pct));
    send_beat(OP_RESTART, $urandom_range(0, 31), $urandom_range(0, 31), 9'($urandom),
              $urandom_range(0, 1023));
    n = 0;
    while (sb.phase == PH_SEARCH && n < max_exp) begin
      p = $urandom_range(0, 99);
      if (p < 88)
        send_beat(OP_EXPAND, $urandom_range(0, 31), $urandom_range(0, 31), 9'($urandom),
                  $urandom_range(0, 1023));
      else if (p < 94)
        send_beat(OP_READ, 0, 0, 0, $urandom_range(0, 1023));
      else
        load_cell($urandom_range(0, uw - 1), $urandom_range(0, uh - 1), pick_cost(blk_pct));
      n++;
    end
    // one more expand: finished status once the search is over
    send_beat(OP_EXPAND, 0, 0, 0, 0);
    if (sb.phase == PH_FOUND) begin
      for (k = 0; k <= sb.plen; k++) send_beat(OP_READ, 0, 0, 0, k);
      send_beat(OP_READ, 0, 0, 0, 1023);
    end
  endtask

  int unsigned wait_cnt;
  int unsigned w, h;

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; op = OP_LOAD; cell_col = '0; cell_row = '0; cell_cost = '0;
    path_index = '0;
    beats_sent = 0; burst_left = 0; phases_run = 0;
    foreach (loaded[i]) loaded[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: expand and reads before any search, load extremes
    send_beat(OP_EXPAND, 0, 0, 0, 0);        // idle: empty open list
    send_beat(OP_READ, 0, 0, 0, 0);          // no path yet
    send_beat(OP_READ, 0, 0, 0, 1023);
    load_cell(31, 31, -9'sd1);
    load_cell(0, 0, 9'sd255);
    load_cell(31, 0, 9'sd0);
    load_cell(0, 31, 9'sd1);
    load_cell(21, 10, 9'sd170);
    load_cell(10, 21, 9'sd85);

    // single cell grid (size 0 clamps to 1): start is the goal
    run_phase(0, 0, 0, 0, 0, 0, 4, 0);
    // start outside the used grid: nothing opened
    run_phase(2, 3, 5, 1, 0, 0, 4, 0);
    // goal outside the used grid: search exhausts
    run_phase(3, 2, 0, 0, 20, 1, 20, 0);
    // heavily blocked grid, likely no path
    run_phase(5, 5, 0, 0, 4, 4, 40, 60);
    // full width, then full height (oversize registers clamp to 32), end to end
    run_phase(63, 1, 31, 0, 0, 0, 12, 15);
    run_phase(1, 40, 0, 31, 0, 0, 12, 15);

    // random searches on small grids
    while (beats_sent < 540) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0)
        run_phase(w, h, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 31), 30, 20);
      else
        run_phase(w, h, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                  $urandom_range(0, w - 1), $urandom_range(0, h - 1), 40,
                  $urandom_range(0, 30));
    end

    in_valid = 1'b0;
    wait_cnt = 0;
    while (sb.owed.size() != 0 && wait_cnt < 200000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (50) @(negedge clk);
    if (sb.owed.size() != 0) begin
      sb.errors += sb.owed.size();
      $display("ERROR: %0d result beats never arrived", sb.owed.size());
    end

    $display("Ran %0d searches, %0d command beats, %0d result beats checked",
             phases_run, beats_sent, sb.checked);
    $display("Expansions %0d, goals reached %0d, dead ends %0d, mismatches %0d",
             sb.expands, sb.goals, sb.dead_ends, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
